[sv/jts_pkg.sv]
// Shared types, codes and helper functions of the JSON token scanner.
// No dependencies; the design modules, the checker and the testbench import this package.
`default_nettype none
package jts_pkg;

   localparam int LINE_BITS_DEF   = 24;
   localparam int COLUMN_BITS_DEF = 16;
   localparam int MAX_RES         = 8;
   localparam int QUEUE_DEPTH     = 2;

   // event kinds
   localparam logic [1:0] EV_START   = 2'd0;
   localparam logic [1:0] EV_PAYLOAD = 2'd1;
   localparam logic [1:0] EV_END     = 2'd2;
   localparam logic [1:0] EV_EOF     = 2'd3;

   // token kinds
   localparam logic [3:0] TK_LBRACE  = 4'd0;
   localparam logic [3:0] TK_RBRACE  = 4'd1;
   localparam logic [3:0] TK_LBRACK  = 4'd2;
   localparam logic [3:0] TK_RBRACK  = 4'd3;
   localparam logic [3:0] TK_COLON   = 4'd4;
   localparam logic [3:0] TK_COMMA   = 4'd5;
   localparam logic [3:0] TK_STRING  = 4'd6;
   localparam logic [3:0] TK_NUMBER  = 4'd7;
   localparam logic [3:0] TK_BOOLEAN = 4'd8;
   localparam logic [3:0] TK_NULL    = 4'd9;
   localparam logic [3:0] TK_EOF     = 4'd10;

   // one result, position chosen later by the post flag
   typedef struct packed {
      logic [1:0] ev;
      logic [3:0] tk;
      logic [7:0] pl;
      logic       post;
   } entry_type;

   // all results caused by one source byte
   typedef struct packed {
      logic [3:0]                   count;
      entry_type [MAX_RES-1:0]      ent;
   } bundle_type;

   function automatic bundle_type add_ent(input bundle_type bd, input logic [1:0] ev,
                                          input logic [3:0] tk, input logic [7:0] pl,
                                          input logic post);
      bundle_type r;
      r = bd;
      if (r.count < 4'(MAX_RES)) begin
         r.ent[r.count[2:0]] = '{ev: ev, tk: tk, pl: pl, post: post};
         r.count = r.count + 4'd1;
      end
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
      else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
      else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
      return r;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic [7:0] true_char(input logic [1:0] i);
      logic [7:0] r;
      case (i)
         2'd0: r = "t";
         2'd1: r = "r";
         2'd2: r = "u";
         default: r = "e";
      endcase
      return r;
   endfunction

   function automatic logic [7:0] false_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0: r = "f";
         3'd1: r = "a";
         3'd2: r = "l";
         3'd3: r = "s";
         default: r = "e";
      endcase
      return r;
   endfunction

   function automatic logic [7:0] null_char(input logic [1:0] i);
      logic [7:0] r;
      case (i)
         2'd0: r = "n";
         2'd1: r = "u";
         default: r = "l";
      endcase
      return r;
   endfunction

   // bit0 true, bit1 false, bit2 null
   function automatic logic [2:0] word_flags(input logic [2:0] flags, input logic [2:0] len,
                                             input logic [7:0] b);
      logic [2:0] r;
      r = flags;
      if (!(len < 3'd4 && b == true_char(len[1:0]))) r[0] = 1'b0;
      if (!(len < 3'd5 && b == false_char(len))) r[1] = 1'b0;
      if (!(len < 3'd4 && b == null_char(len[1:0]))) r[2] = 1'b0;
      return r;
   endfunction

   function automatic logic [3:0] word_kind(input logic [2:0] len, input logic [2:0] flags);
      logic [3:0] r;
      r = TK_STRING;
      if (len == 3'd4 && flags[0]) r = TK_BOOLEAN;
      else if (len == 3'd5 && flags[1]) r = TK_BOOLEAN;
      else if (len == 3'd4 && flags[2]) r = TK_NULL;
      return r;
   endfunction

endpackage
`default_nettype wire

[sv/jts_if.sv]
// Valid/ready channels of the JSON token scanner: source bytes in, events out.
// Depends on nothing.
`default_nettype none
interface jts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       final_byte;
   modport source (output valid, output source_byte, output final_byte, input ready);
   modport sink (input valid, input source_byte, input final_byte, output ready);
endinterface

interface jts_rsp_if #(parameter int LINE_BITS = 24, parameter int COLUMN_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [1:0]             event_kind;
   logic [3:0]             token_kind;
   logic [7:0]             payload;
   logic [LINE_BITS-1:0]   line_number;
   logic [COLUMN_BITS-1:0] column_number;
   logic                   run_end;
   modport source (output valid, output event_kind, output token_kind, output payload,
                   output line_number, output column_number, output run_end, input ready);
   modport sink (input valid, input event_kind, input token_kind, input payload,
                 input line_number, input column_number, input run_end, output ready);
endinterface
`default_nettype wire

[sv/jts_front.sv]
// Front end: accepts source bytes, runs the lexer state and builds one
// bundle of events per byte. Depends on jts_pkg.
`default_nettype none
module jts_front import jts_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      in_valid,
   output logic                                           in_ready,
   input  wire logic [7:0]                                in_byte,
   input  wire logic                                      in_final,
   output logic                                           push,
   input  wire logic                                      push_ready,
   output bundle_type                                     push_bundle,
   output logic [2*(LINE_BITS+COLUMN_BITS)-1:0]           push_pos
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_STRING = 3'd1;
   localparam logic [2:0] MODE_ESCAPE = 3'd2;
   localparam logic [2:0] MODE_HEX    = 3'd3;
   localparam logic [2:0] MODE_NUMBER = 3'd4;
   localparam logic [2:0] MODE_WORD   = 3'd5;

   localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

   logic [2:0]             mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [15:0]            hexv_ff, hexv_in;
   logic [2:0]             hexn_ff, hexn_in;
   logic [2:0][7:0]        hext_ff, hext_in;
   logic [2:0]             wlen_ff, wlen_in;
   logic [2:0]             wflags_ff, wflags_in;
   logic [LINE_BITS-1:0]   line_new;
   logic [COLUMN_BITS-1:0] col_new;
   bundle_type             bund;
   logic                   accept;

   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;
   assign push     = accept && (bund.count != 4'd0);
   assign push_bundle = bund;
   assign push_pos = {line_ff, col_ff, line_new, col_new};

   // Scan one byte: at most two passes, since ending a token or abandoning a hex escape rescans the byte
   always_comb begin
      logic [7:0]  b;
      logic        last;
      logic        again;
      logic        moved;
      logic        sym;
      logic [3:0]  symk;
      logic [4:0]  hd;
      logic [15:0] cp;
      b = in_byte;
      last = in_final;
      mode_in = mode_ff;
      line_in = line_ff;
      col_in = col_ff;
      hexv_in = hexv_ff;
      hexn_in = hexn_ff;
      hext_in = hext_ff;
      wlen_in = wlen_ff;
      wflags_in = wflags_ff;
      bund = '0;
      moved = 1'b0;
      again = 1'b1;
      sym = 1'b0;
      symk = TK_LBRACE;
      hd = hex_digit(b);
      cp = 16'd0;
      case (b)
         "{": begin sym = 1'b1; symk = TK_LBRACE; end
         "}": begin sym = 1'b1; symk = TK_RBRACE; end
         "[": begin sym = 1'b1; symk = TK_LBRACK; end
         "]": begin sym = 1'b1; symk = TK_RBRACK; end
         ":": begin sym = 1'b1; symk = TK_COLON; end
         ",": begin sym = 1'b1; symk = TK_COMMA; end
         default: sym = 1'b0;
      endcase
      for (int pass = 0; pass < 2; pass++) begin
         if (again) begin
            again = 1'b0;
            case (mode_in)
               MODE_STRING: begin
                  if (b == "\"") begin
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                     bund = add_ent(bund, EV_END, TK_STRING, 8'd0, moved);
                     mode_in = MODE_IDLE;
                  end else if (b == "\\") begin
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                     mode_in = MODE_ESCAPE;
                  end else begin
                     if (b == 8'h0A) begin
                        if (line_in != LINE_MAX) line_in = line_in + LINE_ONE;
                        col_in = COL_ONE;
                     end else if (col_in != COL_MAX) begin
                        col_in = col_in + COL_ONE;
                     end
                     moved = 1'b1;
                     bund = add_ent(bund, EV_PAYLOAD, TK_STRING, b, moved);
                  end
               end
               MODE_ESCAPE: begin
                  if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                  moved = 1'b1;
                  if (b == "u") begin
                     hexv_in = 16'd0;
                     hexn_in = 3'd0;
                     mode_in = MODE_HEX;
                  end else begin
                     case (b)
                        "b": bund = add_ent(bund, EV_PAYLOAD, TK_STRING, 8'h08, moved);
                        "f": bund = add_ent(bund, EV_PAYLOAD, TK_STRING, 8'h0C, moved);
                        "n": bund = add_ent(bund, EV_PAYLOAD, TK_STRING, 8'h0A, moved);
                        "r": bund = add_ent(bund, EV_PAYLOAD, TK_STRING, 8'h0D, moved);
                        "t": bund = add_ent(bund, EV_PAYLOAD, TK_STRING, 8'h09, moved);
                        default: bund = add_ent(bund, EV_PAYLOAD, TK_STRING, b, moved);
                     endcase
                     mode_in = MODE_STRING;
                  end
               end
               MODE_HEX: begin
                  if (!hd[4]) begin
                     // not a hex digit: give back the escape text, rescan as string
                     if (!last) bund = add_ent(bund, EV_PAYLOAD, TK_STRING, "\\", moved);
                     bund = add_ent(bund, EV_PAYLOAD, TK_STRING, "u", moved);
                     for (int k = 0; k < 3; k++) begin
                        if (3'(k) < hexn_in)
                           bund = add_ent(bund, EV_PAYLOAD, TK_STRING, hext_in[k], moved);
                     end
                     hexv_in = 16'd0;
                     hexn_in = 3'd0;
                     mode_in = MODE_STRING;
                     again = 1'b1;
                  end else begin
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                     if (hexn_in < 3'd3) hext_in[hexn_in[1:0]] = b;
                     hexv_in = {hexv_in[11:0], hd[3:0]};
                     hexn_in = hexn_in + 3'd1;
                     if (hexn_in >= 3'd4) begin
                        // emit the code point as UTF-8
                        cp = hexv_in;
                        if (cp <= 16'h007F) begin
                           bund = add_ent(bund, EV_PAYLOAD, TK_STRING, cp[7:0], moved);
                        end else if (cp <= 16'h07FF) begin
                           bund = add_ent(bund, EV_PAYLOAD, TK_STRING, {3'b110, cp[10:6]},
                                          moved);
                           bund = add_ent(bund, EV_PAYLOAD, TK_STRING, {2'b10, cp[5:0]},
                                          moved);
                        end else begin
                           bund = add_ent(bund, EV_PAYLOAD, TK_STRING, {4'b1110, cp[15:12]},
                                          moved);
                           bund = add_ent(bund, EV_PAYLOAD, TK_STRING, {2'b10, cp[11:6]},
                                          moved);
                           bund = add_ent(bund, EV_PAYLOAD, TK_STRING, {2'b10, cp[5:0]},
                                          moved);
                        end
                        hexv_in = 16'd0;
                        hexn_in = 3'd0;
                        mode_in = MODE_STRING;
                     end
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit(b) || b == "." || b == "-" || b == "e" || b == "E") begin
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                     bund = add_ent(bund, EV_PAYLOAD, TK_NUMBER, b, moved);
                  end else begin
                     bund = add_ent(bund, EV_END, TK_NUMBER, 8'd0, moved);
                     mode_in = MODE_IDLE;
                     again = 1'b1;
                  end
               end
               MODE_WORD: begin
                  if (is_alpha(b)) begin
                     wflags_in = word_flags(wflags_in, wlen_in, b);
                     if (wlen_in < 3'd6) wlen_in = wlen_in + 3'd1;
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                     bund = add_ent(bund, EV_PAYLOAD, TK_STRING, b, moved);
                  end else begin
                     bund = add_ent(bund, EV_END, word_kind(wlen_in, wflags_in), 8'd0, moved);
                     mode_in = MODE_IDLE;
                     again = 1'b1;
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
                  if (sym) begin
                     bund = add_ent(bund, EV_START, symk, 8'd0, moved);
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                     bund = add_ent(bund, EV_PAYLOAD, symk, b, moved);
                     bund = add_ent(bund, EV_END, symk, 8'd0, moved);
                  end else if (b == "\"") begin
                     bund = add_ent(bund, EV_START, TK_STRING, 8'd0, moved);
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                     mode_in = MODE_STRING;
                  end else if (is_digit(b) || b == "-") begin
                     bund = add_ent(bund, EV_START, TK_NUMBER, 8'd0, moved);
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                     bund = add_ent(bund, EV_PAYLOAD, TK_NUMBER, b, moved);
                     mode_in = MODE_NUMBER;
                  end else if (is_alpha(b)) begin
                     bund = add_ent(bund, EV_START, TK_STRING, 8'd0, moved);
                     wflags_in = word_flags(3'b111, 3'd0, b);
                     wlen_in = 3'd1;
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                     bund = add_ent(bund, EV_PAYLOAD, TK_STRING, b, moved);
                     mode_in = MODE_WORD;
                  end else if (b == 8'h0A) begin
                     if (line_in != LINE_MAX) line_in = line_in + LINE_ONE;
                     col_in = COL_ONE;
                     moved = 1'b1;
                  end else begin
                     if (col_in != COL_MAX) col_in = col_in + COL_ONE;
                     moved = 1'b1;
                  end
               end
            endcase
         end
      end
      // end of input: close what is open and return to reset state
      if (last) begin
         if (mode_in == MODE_HEX) begin
            bund = add_ent(bund, EV_PAYLOAD, TK_STRING, "u", moved);
            for (int k = 0; k < 3; k++) begin
               if (3'(k) < hexn_in)
                  bund = add_ent(bund, EV_PAYLOAD, TK_STRING, hext_in[k], moved);
            end
            mode_in = MODE_STRING;
         end
         if (mode_in == MODE_ESCAPE) begin
            bund = add_ent(bund, EV_PAYLOAD, TK_STRING, "\\", moved);
            mode_in = MODE_STRING;
         end
         if (mode_in == MODE_STRING)
            bund = add_ent(bund, EV_END, TK_STRING, 8'd0, moved);
         else if (mode_in == MODE_NUMBER)
            bund = add_ent(bund, EV_END, TK_NUMBER, 8'd0, moved);
         else if (mode_in == MODE_WORD)
            bund = add_ent(bund, EV_END, word_kind(wlen_in, wflags_in), 8'd0, moved);
         bund = add_ent(bund, EV_EOF, TK_EOF, 8'd0, moved);
      end
      line_new = line_in;
      col_new = col_in;
      if (last) begin
         mode_in = MODE_IDLE;
         line_in = LINE_ONE;
         col_in = COL_ONE;
         hexv_in = 16'd0;
         hexn_in = 3'd0;
         wlen_in = 3'd0;
         wflags_in = 3'b111;
      end
   end

   // Advance lexer state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= LINE_ONE;
         col_ff <= COL_ONE;
         hexv_ff <= 16'd0;
         hexn_ff <= 3'd0;
         wlen_ff <= 3'd0;
         wflags_ff <= 3'b111;
      end else if (accept) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff <= col_in;
         hexv_ff <= hexv_in;
         hexn_ff <= hexn_in;
         wlen_ff <= wlen_in;
         wflags_ff <= wflags_in;
      end
   end

   // Hex digit text is payload only
   always_ff @(posedge clock) begin
      if (accept) hext_ff <= hext_in;
   end

endmodule
`default_nettype wire

[sv/jts_queue.sv]
// Short FIFO of event bundles between front and back end.
// Depends on jts_pkg for the default depth.
`default_nettype none
module jts_queue import jts_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_pop,
   output logic [WIDTH-1:0]      rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, rptr_ff;
   logic [CW-1:0]    cnt_ff;
   logic             do_wr, do_rd;

   assign wr_ready = cnt_ff != CW'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = slot_ff[rptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_pop && rd_valid;

   // Store on write
   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wptr_ff] <= wr_data;
   end

   // Move pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_wr) wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
         if (do_rd) rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
         if (do_wr && !do_rd) cnt_ff <= cnt_ff + CW'(1);
         else if (do_rd && !do_wr) cnt_ff <= cnt_ff - CW'(1);
      end
   end

endmodule
`default_nettype wire

[sv/jts_back.sv]
// Back end: drains a bundle into the output register, one event per cycle while out_ready is high.
// Depends on jts_pkg.
`default_nettype none
module jts_back import jts_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  head_valid,
   output logic                                       head_pop,
   input  wire bundle_type                            head_bundle,
   input  wire logic [2*(LINE_BITS+COLUMN_BITS)-1:0]  head_pos,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output logic [1:0]                                 out_event,
   output logic [3:0]                                 out_token,
   output logic [7:0]                                 out_payload,
   output logic [LINE_BITS-1:0]                       out_line,
   output logic [COLUMN_BITS-1:0]                     out_col,
   output logic                                       out_run_end
);

   logic [2:0]             idx_ff;
   logic                   valid_ff;
   logic [1:0]             ev_ff;
   logic [3:0]             tk_ff;
   logic [7:0]             pl_ff;
   logic [LINE_BITS-1:0]   line_ff;
   logic [COLUMN_BITS-1:0] col_ff;
   logic                   end_ff;
   logic                   load, last_ent;
   entry_type              cur;
   logic [LINE_BITS-1:0]   old_line, new_line;
   logic [COLUMN_BITS-1:0] old_col, new_col;

   assign {old_line, old_col, new_line, new_col} = head_pos;
   assign cur      = head_bundle.ent[idx_ff];
   assign load     = head_valid && (!valid_ff || out_ready);
   assign last_ent = {1'b0, idx_ff} == (head_bundle.count - 4'd1);
   assign head_pop = load && last_ent;

   assign out_valid   = valid_ff;
   assign out_event   = ev_ff;
   assign out_token   = tk_ff;
   assign out_payload = pl_ff;
   assign out_line    = line_ff;
   assign out_col     = col_ff;
   assign out_run_end = end_ff;

   // Step through the bundle's events
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff <= last_ent ? 3'd0 : idx_ff + 3'd1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Load output payload
   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff <= cur.ev;
         tk_ff <= cur.tk;
         pl_ff <= cur.pl;
         line_ff <= cur.post ? new_line : old_line;
         col_ff <= cur.post ? new_col : old_col;
         end_ff <= last_ent;
      end
   end

endmodule
`default_nettype wire

[sv/json_token_scanner.sv]
// JSON token scanner: accepts one source byte per cycle when the queue has room.
// Each byte yields zero to eight events; the back end issues one per cycle while the receiver
// is ready, and a byte's events go through the queue and then the output register.
// Sustained rate is one byte per cycle while bytes average one event or less and the receiver
// is ready; the single-event output register sets the limit otherwise.
// Synchronous reset returns the lexer to idle at line 1, column 1 and empties the queue.
`default_nettype none
module json_token_scanner import jts_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   jts_req_if.sink  req,
   jts_rsp_if.source rsp
);

   localparam int POS_W = 2 * (LINE_BITS + COLUMN_BITS);
   localparam int QW    = POS_W + $bits(bundle_type);

   logic             push, push_ready, head_valid, head_pop;
   bundle_type       push_bundle, head_bundle;
   logic [POS_W-1:0] push_pos, head_pos;

   jts_front #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_byte(req.source_byte), .in_final(req.final_byte),
      .push(push), .push_ready(push_ready),
      .push_bundle(push_bundle), .push_pos(push_pos)
   );

   jts_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(push), .wr_ready(push_ready), .wr_data({push_pos, push_bundle}),
      .rd_valid(head_valid), .rd_pop(head_pop), .rd_data({head_pos, head_bundle})
   );

   jts_back #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_back (
      .clock(clock), .reset(reset),
      .head_valid(head_valid), .head_pop(head_pop),
      .head_bundle(head_bundle), .head_pos(head_pos),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_event(rsp.event_kind), .out_token(rsp.token_kind),
      .out_payload(rsp.payload), .out_line(rsp.line_number),
      .out_col(rsp.column_number), .out_run_end(rsp.run_end)
   );

endmodule
`default_nettype wire

[sv/jts_checker.sv]
// Port-level checks of the JSON token scanner, bound to the top level.
// Depends on jts_pkg and json_token_scanner.
`default_nettype none
module jts_checker import jts_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [1:0]             event_kind,
   input wire logic [3:0]             token_kind,
   input wire logic [7:0]             payload,
   input wire logic [LINE_BITS-1:0]   line_number,
   input wire logic [COLUMN_BITS-1:0] column_number,
   input wire logic                   run_end
);

   // stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_kind) && $stable(token_kind)
         && $stable(payload) && $stable(line_number) && $stable(column_number))
      else $error("output changed while stalled");

   // end of input is always the last event of its byte
   a_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_kind == EV_EOF |-> token_kind == TK_EOF && run_end)
      else $error("bad end-of-input event");

   // positions start at one
   a_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> line_number != '0 && column_number != '0)
      else $error("zero position");

   // only payload events carry a byte
   a_pl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_kind != EV_PAYLOAD |-> payload == 8'd0)
      else $error("payload on non-payload event");

   // reset empties the output
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind json_token_scanner jts_checker #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_chk (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .event_kind(rsp.event_kind), .token_kind(rsp.token_kind), .payload(rsp.payload),
   .line_number(rsp.line_number), .column_number(rsp.column_number), .run_end(rsp.run_end)
);
`default_nettype wire

[test/jts_tb_if.sv]
// Record type shared by the testbench: scanner events.
// Depends on nothing.
`default_nettype none
package jts_tb_util;

   // one expected or observed scanner event
   typedef struct packed {
      logic [1:0]  ev;
      logic [3:0]  tk;
      logic [7:0]  pl;
      logic [23:0] ln;
      logic [15:0] col;
      logic        last;
   } scan_event_type;
endpackage
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench of json_token_scanner: directed table, then random JSON-like text.
// Depends on jts_pkg, jts_if.sv and jts_tb_util; predicts events with its own lexer copy.
`default_nettype none
module testbench;
   import jts_pkg::*;
   import jts_tb_util::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MODE_IDLE = 0, MODE_STR = 1, MODE_ESC = 2, MODE_HEX = 3;
   localparam int MODE_NUM = 4, MODE_WORD = 5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   failed = 1'b0;
   bit   stim_done = 1'b0;
   bit   hold_off = 1'b0;

   jts_req_if req ();
   jts_rsp_if rsp ();

   json_token_scanner i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // lexer state of the predictor
   int          lex_mode;
   logic [23:0] lex_line;
   logic [15:0] lex_col;
   logic [15:0] lex_hex;
   int          lex_hex_cnt;
   logic [7:0]  lex_hex_text [3];
   int          lex_wlen;
   logic [2:0]  lex_wflags;
   scan_event_type pending_events [$];
   scan_event_type byte_events [$];

   // directed table: byte, final flag
   typedef struct { logic [7:0] b; bit f; } src_row_type;
   src_row_type src_queue [$];

   function automatic bit digit_c(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction
   function automatic bit alpha_c(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction
   function automatic int hexval(logic [7:0] b);
      if (digit_c(b)) return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return -1;
   endfunction

   task automatic lex_clear();
      lex_mode = MODE_IDLE;
      lex_line = 24'd1;
      lex_col = 16'd1;
      lex_hex = '0;
      lex_hex_cnt = 0;
      lex_hex_text = '{8'd0, 8'd0, 8'd0};
      lex_wlen = 0;
      lex_wflags = 3'b111;
   endtask

   task automatic push_event(logic [1:0] ev, logic [3:0] tk, logic [7:0] pl);
      scan_event_type e;
      e = '{ev, tk, pl, lex_line, lex_col, 1'b0};
      if (byte_events.size() < MAX_RES)
         byte_events.insert(byte_events.size(), e);
   endtask

   task automatic bump_col();
      if (lex_col != 16'hFFFF) lex_col++;
   endtask

   task automatic bump_line();
      if (lex_line != 24'hFFFFFF) lex_line++;
      lex_col = 16'd1;
   endtask

   task automatic word_track(logic [7:0] b);
      string t, fa, nu;
      t = "true";
      fa = "false";
      nu = "null";
      if (!(lex_wlen < 4 && b == t[lex_wlen])) lex_wflags[0] = 1'b0;
      if (!(lex_wlen < 5 && b == fa[lex_wlen])) lex_wflags[1] = 1'b0;
      if (!(lex_wlen < 4 && b == nu[lex_wlen])) lex_wflags[2] = 1'b0;
      if (lex_wlen < 6) lex_wlen++;
   endtask

   function automatic logic [3:0] word_token();
      if (lex_wlen == 4 && lex_wflags[0]) return TK_BOOLEAN;
      if (lex_wlen == 5 && lex_wflags[1]) return TK_BOOLEAN;
      if (lex_wlen == 4 && lex_wflags[2]) return TK_NULL;
      return TK_STRING;
   endfunction

   task automatic hex_dump(bit with_bs);
      if (with_bs) push_event(EV_PAYLOAD, TK_STRING, "\\");
      push_event(EV_PAYLOAD, TK_STRING, "u");
      for (int k = 0; k < lex_hex_cnt && k < 3; k++)
         push_event(EV_PAYLOAD, TK_STRING, lex_hex_text[k]);
      lex_hex = '0;
      lex_hex_cnt = 0;
      lex_mode = MODE_STR;
   endtask

   task automatic scan_between(logic [7:0] b);
      logic [3:0] sym;
      bit is_sym;
      is_sym = 1'b1;
      case (b)
         "{": sym = TK_LBRACE;
         "}": sym = TK_RBRACE;
         "[": sym = TK_LBRACK;
         "]": sym = TK_RBRACK;
         ":": sym = TK_COLON;
         ",": sym = TK_COMMA;
         default: begin
            is_sym = 1'b0;
            sym = TK_EOF;
         end
      endcase
      if (is_sym) begin
         push_event(EV_START, sym, 8'd0);
         bump_col();
         push_event(EV_PAYLOAD, sym, b);
         push_event(EV_END, sym, 8'd0);
      end else if (b == "\"") begin
         push_event(EV_START, TK_STRING, 8'd0);
         bump_col();
         lex_mode = MODE_STR;
      end else if (digit_c(b) || b == "-") begin
         push_event(EV_START, TK_NUMBER, 8'd0);
         bump_col();
         push_event(EV_PAYLOAD, TK_NUMBER, b);
         lex_mode = MODE_NUM;
      end else if (alpha_c(b)) begin
         push_event(EV_START, TK_STRING, 8'd0);
         lex_wlen = 0;
         lex_wflags = 3'b111;
         word_track(b);
         bump_col();
         push_event(EV_PAYLOAD, TK_STRING, b);
         lex_mode = MODE_WORD;
      end else if (b == 8'h0A) begin
         bump_line();
      end else begin
         bump_col();
      end
   endtask

   // sets again when the byte must be rescanned in the new mode
   task automatic scan_in_hex(input logic [7:0] b, input bit fin, output bit again);
      int d;
      logic [15:0] cp;
      again = 1'b0;
      d = hexval(b);
      if (d < 0) begin
         hex_dump(!fin);
         again = 1'b1;
         return;
      end
      bump_col();
      if (lex_hex_cnt < 3) lex_hex_text[lex_hex_cnt] = b;
      lex_hex = {lex_hex[11:0], 4'(d)};
      lex_hex_cnt++;
      if (lex_hex_cnt >= 4) begin
         cp = lex_hex;
         if (cp <= 16'h7F) begin
            push_event(EV_PAYLOAD, TK_STRING, cp[7:0]);
         end else if (cp <= 16'h7FF) begin
            push_event(EV_PAYLOAD, TK_STRING, 8'hC0 | 8'(cp >> 6));
            push_event(EV_PAYLOAD, TK_STRING, 8'h80 | 8'(cp & 16'h3F));
         end else begin
            push_event(EV_PAYLOAD, TK_STRING, 8'hE0 | 8'(cp >> 12));
            push_event(EV_PAYLOAD, TK_STRING, 8'h80 | 8'((cp >> 6) & 16'h3F));
            push_event(EV_PAYLOAD, TK_STRING, 8'h80 | 8'(cp & 16'h3F));
         end
         lex_hex = '0;
         lex_hex_cnt = 0;
         lex_mode = MODE_STR;
      end
   endtask

   // predict every event caused by one source byte
   task automatic predict_byte(logic [7:0] b, bit fin);
      bit again;
      logic [7:0] c;
      byte_events.delete();
      for (int pass = 0; pass < 2; pass++) begin
         again = 1'b0;
         case (lex_mode)
            MODE_STR: begin
               if (b == "\"") begin
                  bump_col();
                  push_event(EV_END, TK_STRING, 8'd0);
                  lex_mode = MODE_IDLE;
               end else if (b == "\\") begin
                  bump_col();
                  lex_mode = MODE_ESC;
               end else begin
                  if (b == 8'h0A) bump_line(); else bump_col();
                  push_event(EV_PAYLOAD, TK_STRING, b);
               end
            end
            MODE_ESC: begin
               bump_col();
               if (b == "u") begin
                  lex_hex = '0;
                  lex_hex_cnt = 0;
                  lex_mode = MODE_HEX;
               end else begin
                  c = b;
                  case (b)
                     "b": c = 8'h08;
                     "f": c = 8'h0C;
                     "n": c = 8'h0A;
                     "r": c = 8'h0D;
                     "t": c = 8'h09;
                     default: c = b;
                  endcase
                  push_event(EV_PAYLOAD, TK_STRING, c);
                  lex_mode = MODE_STR;
               end
            end
            MODE_HEX: scan_in_hex(b, fin, again);
            MODE_NUM: begin
               if (digit_c(b) || b == "." || b == "-" || b == "e" || b == "E") begin
                  bump_col();
                  push_event(EV_PAYLOAD, TK_NUMBER, b);
               end else begin
                  push_event(EV_END, TK_NUMBER, 8'd0);
                  lex_mode = MODE_IDLE;
                  again = 1'b1;
               end
            end
            MODE_WORD: begin
               if (alpha_c(b)) begin
                  word_track(b);
                  bump_col();
                  push_event(EV_PAYLOAD, TK_STRING, b);
               end else begin
                  push_event(EV_END, word_token(), 8'd0);
                  lex_mode = MODE_IDLE;
                  again = 1'b1;
               end
            end
            default: begin
               lex_mode = MODE_IDLE;
               scan_between(b);
            end
         endcase
         if (!again) break;
      end
      if (fin) begin
         if (lex_mode == MODE_HEX) hex_dump(1'b0);
         if (lex_mode == MODE_ESC) begin
            push_event(EV_PAYLOAD, TK_STRING, "\\");
            lex_mode = MODE_STR;
         end
         if (lex_mode == MODE_STR) push_event(EV_END, TK_STRING, 8'd0);
         else if (lex_mode == MODE_NUM) push_event(EV_END, TK_NUMBER, 8'd0);
         else if (lex_mode == MODE_WORD) push_event(EV_END, word_token(), 8'd0);
         push_event(EV_EOF, TK_EOF, 8'd0);
         lex_clear();
      end
      if (byte_events.size() > 0) byte_events[byte_events.size()-1].last = 1'b1;
      foreach (byte_events[i]) pending_events.insert(pending_events.size(), byte_events[i]);
   endtask

   // append one source byte to the stimulus table
   task automatic add_byte(logic [7:0] b, bit f);
      src_row_type row;
      row.b = b;
      row.f = f;
      src_queue.insert(src_queue.size(), row);
   endtask

   task automatic add_text(string s, bit fin_at_end);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i], fin_at_end && i == s.len() - 1);
   endtask

   // random JSON-ish fragment, mostly well formed
   task automatic add_random_piece();
      string alph;
      int n;
      alph = "0123456789abcdefABCDEF";
      case ($urandom_range(0, 11))
         0: add_text("{", 0);
         1: add_text(",", 0);
         2: add_text($urandom_range(0, 1) ? "]" : ":", 0);
         3: begin
            add_text("\"", 0);
            n = $urandom_range(0, 4);
            repeat (n) add_byte(8'($urandom_range(32, 126)), 1'b0);
            if ($urandom_range(0, 1)) begin
               add_text("\\u", 0);
               repeat ($urandom_range(0, 4)) add_byte(alph[$urandom_range(0, 21)], 1'b0);
            end else if ($urandom_range(0, 1)) begin
               add_text("\\", 0);
               add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            add_text("\"", 0);
         end
         4: begin
            n = $urandom_range(1, 5);
            repeat (n) add_byte("0" + 8'($urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 1)) add_text("e-5", 0);
         end
         5: add_text($urandom_range(0, 1) ? "true" : "false", 0);
         6: add_text($urandom_range(0, 1) ? "null" : "nulls", 0);
         7: add_text(" \n", 0);
         8: add_byte(8'($urandom_range(0, 255)), 1'b0);
         9: add_byte(8'($urandom_range(128, 255)), 1'b0);
         10: add_text("[\"a\"]", 0);
         default: add_byte(8'($urandom), 1'($urandom_range(0, 15) == 0));
      endcase
   endtask

   // drive source bytes in bursts with gaps
   initial begin
      int burst;
      req.valid <= 1'b0;
      req.source_byte <= '0;
      req.final_byte <= 1'b0;
      lex_clear();
      // extremes, every token, escapes, hex fallbacks and short tails
      add_text("{\"k\":[1,-2.5e3]}", 0);
      add_text("\"\\n\\t\\b\\f\\r\\\"\\/\\x\"", 0);
      add_text("\"\\u0041\\u00e9\\uFFFF\\u12G\"", 0);
      add_text("true false null nul True\n", 0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_text("\"\\u12", 1);
      add_text("\"\\uZ", 1);
      add_text("\"ab\\", 1);
      add_text("42", 1);
      add_text("fals", 1);
      add_text("\"open", 1);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (src_queue.size() < 269) add_random_piece();
      add_byte("}", 1'b1);
      burst = 0;
      while (src_queue.size() > 0) begin
         if (burst == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            burst = $urandom_range(1, 24);
         end
         req.valid <= 1'b1;
         req.source_byte <= src_queue[0].b;
         req.final_byte <= src_queue[0].f;
         @(posedge clock);
         while (!req.ready) @(posedge clock);
         predict_byte(src_queue[0].b, src_queue[0].f);
         void'(src_queue.pop_front());
         burst--;
      end
      req.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver stalls, with one long hold-off
   initial begin
      int cyc;
      rsp.ready <= 1'b0;
      cyc = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cyc++;
         hold_off = cyc >= 150 && cyc < 260;
         rsp.ready <= !hold_off && (cyc % 64 < 32 || $urandom_range(0, 3) != 0);
      end
   end

   // compare each accepted event with the oldest prediction
   always @(posedge clock) begin
      scan_event_type exp_ev;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_events.size() == 0) begin
            $error("unexpected event kind %0d token %0d", rsp.event_kind, rsp.token_kind);
            failed = 1'b1;
         end else begin
            exp_ev = pending_events.pop_front();
            if (rsp.event_kind !== exp_ev.ev) begin
               $error("event_kind expected %0d got %0d", exp_ev.ev, rsp.event_kind);
               failed = 1'b1;
            end
            if (rsp.token_kind !== exp_ev.tk) begin
               $error("token_kind expected %0d got %0d", exp_ev.tk, rsp.token_kind);
               failed = 1'b1;
            end
            if (rsp.payload !== exp_ev.pl) begin
               $error("payload expected %0h got %0h", exp_ev.pl, rsp.payload);
               failed = 1'b1;
            end
            if (rsp.line_number !== exp_ev.ln) begin
               $error("line_number expected %0d got %0d", exp_ev.ln, rsp.line_number);
               failed = 1'b1;
            end
            if (rsp.column_number !== exp_ev.col) begin
               $error("column_number expected %0d got %0d", exp_ev.col, rsp.column_number);
               failed = 1'b1;
            end
            if (rsp.run_end !== exp_ev.last) begin
               $error("run_end expected %0d got %0d", exp_ev.last, rsp.run_end);
               failed = 1'b1;
            end
         end
      end
   end

   // drain, settle, report
   initial begin
      @(negedge reset);
      wait (stim_done);
      while (pending_events.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_events.size() == 0 && !failed) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
